// ===== hw/rtl/v3au_pkg.sv =====
// Shared types, constants and helper functions of the vector arithmetic unit.
// Used by the top level and by the square root and divider pipelines.
// No dependencies.
package v3au_pkg;

   localparam int DATA_W      = 32;
   localparam int FRAC_W      = 16;
   localparam int SQ_IN_W     = 2 * DATA_W;
   localparam int SQ_ROOT_W   = DATA_W;
   localparam int SQRT_STAGES = SQ_ROOT_W;
   localparam int DIV_STAGES  = FRAC_W + 1;
   localparam int SIDE_DEPTH  = 1 + SQRT_STAGES + DIV_STAGES;
   localparam int PIPE_DEPTH  = 3 + SQRT_STAGES + DIV_STAGES + 1;

   localparam logic [3:0] MODE_ADD    = 4'd0;
   localparam logic [3:0] MODE_SUB    = 4'd1;
   localparam logic [3:0] MODE_ADDS   = 4'd2;
   localparam logic [3:0] MODE_SUBS   = 4'd3;
   localparam logic [3:0] MODE_SCALE  = 4'd4;
   localparam logic [3:0] MODE_NEG    = 4'd5;
   localparam logic [3:0] MODE_CROSS  = 4'd6;
   localparam logic [3:0] MODE_DOT    = 4'd7;
   localparam logic [3:0] MODE_MAG    = 4'd8;
   localparam logic [3:0] MODE_UNIT   = 4'd9;
   localparam logic [3:0] MODE_EQUALS = 4'd10;

   typedef struct packed {
      logic [3:0]               mode;
      logic signed [DATA_W-1:0] a_x;
      logic signed [DATA_W-1:0] a_y;
      logic signed [DATA_W-1:0] a_z;
      logic signed [DATA_W-1:0] b_x;
      logic signed [DATA_W-1:0] b_y;
      logic signed [DATA_W-1:0] b_z;
      logic signed [DATA_W-1:0] scalar_in;
   } req_word_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] r_x;
      logic signed [DATA_W-1:0] r_y;
      logic signed [DATA_W-1:0] r_z;
      logic signed [DATA_W-1:0] scalar_out;
      logic                     is_equal;
      logic                     zero_vector;
   } rsp_word_type;

   // Clamps a wide signed value to the signed DATA_W-bit range.
   function automatic logic signed [DATA_W-1:0] sat_q(input logic signed [65:0] v);
      logic all_ones;
      logic all_zeros;
      all_ones  = &v[65:DATA_W-1];
      all_zeros = ~|v[65:DATA_W-1];
      if (all_ones || all_zeros) begin
         return v[DATA_W-1:0];
      end else if (v[65]) begin
         return {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         return {1'b0, {(DATA_W-1){1'b1}}};
      end
   endfunction

endpackage

// ===== hw/rtl/v3au_sqrt.sv =====
// Pipelined integer square root, one root bit resolved per register stage.
// Depends on v3au_pkg for widths and stage count.
module v3au_sqrt import v3au_pkg::*; (
   input  logic                 clock,
   input  logic [SQ_IN_W-1:0]   radicand,
   output logic [SQ_ROOT_W-1:0] root
);

   logic [SQ_ROOT_W+1:0] rem_ff  [SQRT_STAGES];
   logic [SQ_ROOT_W-1:0] root_ff [SQRT_STAGES];
   logic [SQ_IN_W-1:0]   rad_ff  [SQRT_STAGES];

   for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
      logic [SQ_ROOT_W+1:0] rem_prev;
      logic [SQ_ROOT_W-1:0] root_prev;
      logic [SQ_IN_W-1:0]   rad_prev;
      logic [SQ_ROOT_W+3:0] trial_rem;
      logic [SQ_ROOT_W+3:0] trial;
      logic [SQ_ROOT_W+1:0] rem_in;
      logic [SQ_ROOT_W-1:0] root_in;

      if (k == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rad_prev  = radicand;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign rad_prev  = rad_ff[k-1];
      end

      // Bring down two radicand bits and try the next root bit.
      always_comb begin
         trial_rem = {rem_prev, rad_prev[SQ_IN_W-1:SQ_IN_W-2]};
         trial     = {2'b00, root_prev, 2'b01};
         if (trial_rem >= trial) begin
            rem_in  = (SQ_ROOT_W+2)'(trial_rem - trial);
            root_in = {root_prev[SQ_ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = trial_rem[SQ_ROOT_W+1:0];
            root_in = {root_prev[SQ_ROOT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k]  <= rem_in;
         root_ff[k] <= root_in;
         rad_ff[k]  <= {rad_prev[SQ_IN_W-3:0], 2'b00};
      end
   end

   assign root = root_ff[SQRT_STAGES-1];

endmodule

// ===== hw/rtl/v3au_div.sv =====
// Pipelined divider for one unit vector component: (|c| << FRAC_W) / m with
// the sign of c restored. One quotient bit per register stage. Uses v3au_pkg.
module v3au_div import v3au_pkg::*; (
   input  logic                     clock,
   input  logic signed [DATA_W-1:0] comp,
   input  logic [DATA_W-1:0]        divisor,
   output logic signed [DATA_W-1:0] quot
);

   logic [DATA_W-1:0]     rem_ff  [DIV_STAGES];
   logic [DIV_STAGES-1:0] bits_ff [DIV_STAGES];
   logic [DIV_STAGES-1:0] q_ff    [DIV_STAGES];
   logic [DATA_W-1:0]     div_ff  [DIV_STAGES];
   logic                  neg_ff  [DIV_STAGES];

   logic [DATA_W-1:0] abs_c;
   logic [DATA_W-1:0] q_ext;

   assign abs_c = comp[DATA_W-1] ? DATA_W'(-comp) : DATA_W'(comp);

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
      logic [DATA_W-1:0]     rem_prev;
      logic [DIV_STAGES-1:0] bits_prev;
      logic [DIV_STAGES-1:0] q_prev;
      logic [DATA_W-1:0]     div_prev;
      logic                  neg_prev;
      logic [DATA_W:0]       trial;
      logic [DATA_W-1:0]     rem_in;
      logic                  qbit;

      // The quotient never exceeds one in Q format, so the top numerator
      // bits already form a remainder below the divisor.
      if (k == 0) begin : g_first
         assign rem_prev  = {1'b0, abs_c[DATA_W-1:1]};
         assign bits_prev = {abs_c[0], {(DIV_STAGES-1){1'b0}}};
         assign q_prev    = '0;
         assign div_prev  = divisor;
         assign neg_prev  = comp[DATA_W-1];
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign bits_prev = bits_ff[k-1];
         assign q_prev    = q_ff[k-1];
         assign div_prev  = div_ff[k-1];
         assign neg_prev  = neg_ff[k-1];
      end

      always_comb begin
         trial = {rem_prev, bits_prev[DIV_STAGES-1]};
         if (trial >= {1'b0, div_prev}) begin
            rem_in = DATA_W'(trial - {1'b0, div_prev});
            qbit   = 1'b1;
         end else begin
            rem_in = trial[DATA_W-1:0];
            qbit   = 1'b0;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k]  <= rem_in;
         bits_ff[k] <= {bits_prev[DIV_STAGES-2:0], 1'b0};
         q_ff[k]    <= {q_prev[DIV_STAGES-2:0], qbit};
         div_ff[k]  <= div_prev;
         neg_ff[k]  <= neg_prev;
      end
   end

   assign q_ext = {{(DATA_W-DIV_STAGES){1'b0}}, q_ff[DIV_STAGES-1]};
   assign quot  = neg_ff[DIV_STAGES-1] ? DATA_W'(-q_ext) : q_ext;

endmodule

// ===== hw/rtl/vector3_arithmetic_unit.sv =====
// Three-component vector unit in signed Q16.16. A word is taken in every cycle
// (busy never rises); every mode's result is delayed to match the 32-stage
// square root followed by the 17-stage divider. The receiver cannot stall:
// each result is shown for one cycle under rsp_valid. Results leave in the
// order words entered.
module vector3_arithmetic_unit import v3au_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_word_type req_word,
   output logic         rsp_valid,
   output rsp_word_type rsp_word
);

   typedef struct packed {
      logic [3:0]               mode;
      logic signed [DATA_W-1:0] a_x;
      logic signed [DATA_W-1:0] a_y;
      logic signed [DATA_W-1:0] a_z;
      logic signed [DATA_W-1:0] r_x;
      logic signed [DATA_W-1:0] r_y;
      logic signed [DATA_W-1:0] r_z;
      logic signed [DATA_W-1:0] scalar;
      logic                     is_equal;
   } side_type;

   // Stage 1: input register.
   logic         s1_vld_ff;
   req_word_type s1_ff;

   // Stage 2: products and the simple modes.
   logic                       s2_vld_ff;
   logic signed [2*DATA_W-1:0] p_ff [6];
   logic signed [2*DATA_W-1:0] p_in [6];
   side_type                   s2_ff;
   side_type                   s2_in;

   // Stage 3 onward: side information travels beside square root and divider.
   logic [SIDE_DEPTH-1:0] side_vld_ff;
   side_type              side_ff [SIDE_DEPTH];
   side_type              side_in;
   logic [SQ_IN_W-1:0]    sumsq_ff;
   logic [SQ_IN_W-1:0]    sumsq_in;

   logic [SQ_ROOT_W-1:0] mag;
   logic [SQ_ROOT_W-1:0] mag_ff [DIV_STAGES];
   logic signed [DATA_W-1:0] unit_x;
   logic signed [DATA_W-1:0] unit_y;
   logic signed [DATA_W-1:0] unit_z;

   logic         rsp_valid_ff;
   rsp_word_type rsp_ff;
   rsp_word_type rsp_in;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      s1_ff <= req_word;
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= start && !busy;
      end
   end

   // Products: lanes 0..2 serve scale, dot and squares; lanes 3..5 cross.
   always_comb begin
      logic signed [DATA_W-1:0] op0;
      logic signed [DATA_W-1:0] op1;
      logic signed [DATA_W-1:0] op2;
      logic signed [DATA_W+1:0] o0;
      logic signed [DATA_W+1:0] o1;
      logic signed [DATA_W+1:0] o2;
      logic signed [DATA_W+1:0] t0;
      logic signed [DATA_W+1:0] t1;
      logic signed [DATA_W+1:0] t2;
      if (s1_ff.mode == MODE_SCALE) begin
         op0 = s1_ff.scalar_in;
         op1 = s1_ff.scalar_in;
         op2 = s1_ff.scalar_in;
      end else if (s1_ff.mode == MODE_DOT) begin
         op0 = s1_ff.b_x;
         op1 = s1_ff.b_y;
         op2 = s1_ff.b_z;
      end else begin
         op0 = s1_ff.a_x;
         op1 = s1_ff.a_y;
         op2 = s1_ff.a_z;
      end
      p_in[0] = s1_ff.a_x * op0;
      p_in[1] = s1_ff.a_y * op1;
      p_in[2] = s1_ff.a_z * op2;
      p_in[3] = s1_ff.a_y * s1_ff.b_z;
      p_in[4] = s1_ff.a_z * s1_ff.b_y;
      p_in[5] = s1_ff.a_z * s1_ff.b_x;

      if (s1_ff.mode == MODE_ADD || s1_ff.mode == MODE_SUB) begin
         o0 = (DATA_W+2)'(s1_ff.b_x);
         o1 = (DATA_W+2)'(s1_ff.b_y);
         o2 = (DATA_W+2)'(s1_ff.b_z);
      end else begin
         o0 = (DATA_W+2)'(s1_ff.scalar_in);
         o1 = (DATA_W+2)'(s1_ff.scalar_in);
         o2 = (DATA_W+2)'(s1_ff.scalar_in);
      end
      if (s1_ff.mode == MODE_SUB || s1_ff.mode == MODE_SUBS) begin
         t0 = (DATA_W+2)'(s1_ff.a_x) - o0;
         t1 = (DATA_W+2)'(s1_ff.a_y) - o1;
         t2 = (DATA_W+2)'(s1_ff.a_z) - o2;
      end else if (s1_ff.mode == MODE_NEG) begin
         t0 = (DATA_W+2)'(0) - (DATA_W+2)'(s1_ff.a_x);
         t1 = (DATA_W+2)'(0) - (DATA_W+2)'(s1_ff.a_y);
         t2 = (DATA_W+2)'(0) - (DATA_W+2)'(s1_ff.a_z);
      end else begin
         t0 = (DATA_W+2)'(s1_ff.a_x) + o0;
         t1 = (DATA_W+2)'(s1_ff.a_y) + o1;
         t2 = (DATA_W+2)'(s1_ff.a_z) + o2;
      end

      s2_in      = '0;
      s2_in.mode = s1_ff.mode;
      s2_in.a_x  = s1_ff.a_x;
      s2_in.a_y  = s1_ff.a_y;
      s2_in.a_z  = s1_ff.a_z;
      if (s1_ff.mode <= MODE_SUBS || s1_ff.mode == MODE_NEG) begin
         s2_in.r_x = sat_q(66'(t0));
         s2_in.r_y = sat_q(66'(t1));
         s2_in.r_z = sat_q(66'(t2));
      end
      if (s1_ff.mode == MODE_EQUALS) begin
         s2_in.is_equal = (s1_ff.a_x == s1_ff.b_x) && (s1_ff.a_y == s1_ff.b_y)
                          && (s1_ff.a_z == s1_ff.b_z);
      end
   end

   // The remaining cross terms each have their own multiplier so that
   // stage 3 only subtracts.
   logic signed [2*DATA_W-1:0] p6_ff;
   logic signed [2*DATA_W-1:0] p7_ff;
   logic signed [2*DATA_W-1:0] p8_ff;

   always_ff @(posedge clock) begin
      for (int i = 0; i < 6; i++) begin
         p_ff[i] <= p_in[i];
      end
      p6_ff <= s1_ff.a_x * s1_ff.b_z;
      p7_ff <= s1_ff.a_x * s1_ff.b_y;
      p8_ff <= s1_ff.a_y * s1_ff.b_x;
      s2_ff <= s2_in;
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   // Stage 3: sums, floor shift and saturation.
   always_comb begin
      logic signed [65:0] e [6];
      logic signed [65:0] ex6;
      logic signed [65:0] ex7;
      logic signed [65:0] ex8;
      logic signed [65:0] cx;
      logic signed [65:0] cy;
      logic signed [65:0] cz;
      logic signed [65:0] dot;
      for (int i = 0; i < 6; i++) begin
         e[i] = 66'(p_ff[i]);
      end
      ex6 = 66'(p6_ff);
      ex7 = 66'(p7_ff);
      ex8 = 66'(p8_ff);
      cx  = (e[3] - e[4]) >>> FRAC_W;
      cy  = (e[5] - ex6) >>> FRAC_W;
      cz  = (ex7 - ex8) >>> FRAC_W;
      dot = (e[0] + e[1] + e[2]) >>> FRAC_W;
      sumsq_in = SQ_IN_W'(p_ff[0]) + SQ_IN_W'(p_ff[1]) + SQ_IN_W'(p_ff[2]);
      side_in = s2_ff;
      unique case (s2_ff.mode)
         MODE_SCALE: begin
            side_in.r_x = sat_q(e[0] >>> FRAC_W);
            side_in.r_y = sat_q(e[1] >>> FRAC_W);
            side_in.r_z = sat_q(e[2] >>> FRAC_W);
         end
         MODE_CROSS: begin
            side_in.r_x = sat_q(cx);
            side_in.r_y = sat_q(cy);
            side_in.r_z = sat_q(cz);
         end
         MODE_DOT: begin
            side_in.scalar = sat_q(dot);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      sumsq_ff   <= sumsq_in;
      side_ff[0] <= side_in;
      for (int i = 1; i < SIDE_DEPTH; i++) begin
         side_ff[i] <= side_ff[i-1];
      end
      if (reset) begin
         side_vld_ff <= '0;
      end else begin
         side_vld_ff <= {side_vld_ff[SIDE_DEPTH-2:0], s2_vld_ff};
      end
   end

   v3au_sqrt u_sqrt (
      .clock    (clock),
      .radicand (sumsq_ff),
      .root     (mag)
   );

   v3au_div u_div_x (
      .clock   (clock),
      .comp    (side_ff[SQRT_STAGES].a_x),
      .divisor (mag),
      .quot    (unit_x)
   );

   v3au_div u_div_y (
      .clock   (clock),
      .comp    (side_ff[SQRT_STAGES].a_y),
      .divisor (mag),
      .quot    (unit_y)
   );

   v3au_div u_div_z (
      .clock   (clock),
      .comp    (side_ff[SQRT_STAGES].a_z),
      .divisor (mag),
      .quot    (unit_z)
   );

   always_ff @(posedge clock) begin
      mag_ff[0] <= mag;
      for (int i = 1; i < DIV_STAGES; i++) begin
         mag_ff[i] <= mag_ff[i-1];
      end
   end

   // Final selection: magnitude and unit modes take the late results.
   always_comb begin
      side_type                 last;
      logic [SQ_ROOT_W-1:0]     m;
      last   = side_ff[SIDE_DEPTH-1];
      m      = mag_ff[DIV_STAGES-1];
      rsp_in = '0;
      if (last.mode == MODE_MAG) begin
         rsp_in.scalar_out = m[SQ_ROOT_W-1] ? {1'b0, {(DATA_W-1){1'b1}}} : m;
      end else if (last.mode == MODE_UNIT) begin
         if (m == '0) begin
            rsp_in.zero_vector = 1'b1;
         end else begin
            rsp_in.r_x = unit_x;
            rsp_in.r_y = unit_y;
            rsp_in.r_z = unit_z;
         end
      end else begin
         rsp_in.r_x        = last.r_x;
         rsp_in.r_y        = last.r_y;
         rsp_in.r_z        = last.r_z;
         rsp_in.scalar_out = last.scalar;
         rsp_in.is_equal   = last.is_equal;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= side_vld_ff[SIDE_DEPTH-1];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   a_rsp_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, PIPE_DEPTH))
      else $error("result word without a matching request word");

   a_zero_vector_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.zero_vector |->
         rsp_word.r_x == '0 && rsp_word.r_y == '0 && rsp_word.r_z == '0)
      else $error("zero vector result carries nonzero components");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_word.is_equal && rsp_word.zero_vector))
      else $error("equal and zero vector flags raised together");

   a_equal_no_scalar: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.is_equal |-> rsp_word.scalar_out == '0)
      else $error("equality result carries a scalar");

endmodule

// ===== bench/vector3_arithmetic_unit_checker.sv =====
// Checker for the three-component vector unit: watches accepted request words,
// predicts each response word and compares it, field by field, in order.
// Depends on v3au_pkg for the word types and mode codes.
module vector3_arithmetic_unit_checker import v3au_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic         busy,
   input  req_word_type req_word,
   input  logic         rsp_valid,
   input  rsp_word_type rsp_word,
   output int           failures,
   output int           pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic signed [127:0] QMAX = 128'sh7fffffff;
   localparam logic signed [127:0] QMIN = -128'sh80000000;

   rsp_word_type vector_results[$];

   function automatic logic [31:0] clamp_q(input logic signed [127:0] v);
      if (v > QMAX) begin
         return 32'h7fffffff;
      end else if (v < QMIN) begin
         return 32'h80000000;
      end
      return v[31:0];
   endfunction

   // Floor square root of a nonnegative sum of squares.
   function automatic logic [63:0] floor_root(input logic [127:0] n);
      logic [63:0] root;
      logic [63:0] trial;
      root = '0;
      for (int b = 63; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if ({64'd0, trial} * {64'd0, trial} <= n) begin
            root = trial;
         end
      end
      return root;
   endfunction

   function automatic rsp_word_type vector_result(input req_word_type w);
      rsp_word_type r;
      logic signed [127:0] a [3];
      logic signed [127:0] b [3];
      logic signed [127:0] s;
      logic signed [127:0] acc;
      logic [127:0] sumsq;
      logic [127:0] q;
      logic [63:0] mag;
      logic [31:0] rv [3];
      r = '0;
      a[0] = $signed(w.a_x);
      a[1] = $signed(w.a_y);
      a[2] = $signed(w.a_z);
      b[0] = $signed(w.b_x);
      b[1] = $signed(w.b_y);
      b[2] = $signed(w.b_z);
      s = $signed(w.scalar_in);
      rv[0] = '0;
      rv[1] = '0;
      rv[2] = '0;
      case (w.mode)
         MODE_ADD, MODE_SUB, MODE_ADDS, MODE_SUBS: begin
            for (int i = 0; i < 3; i++) begin
               acc = (w.mode == MODE_ADD || w.mode == MODE_SUB) ? b[i] : s;
               rv[i] = (w.mode == MODE_ADD || w.mode == MODE_ADDS)
                       ? clamp_q(a[i] + acc) : clamp_q(a[i] - acc);
            end
         end
         MODE_SCALE: begin
            for (int i = 0; i < 3; i++) rv[i] = clamp_q((a[i] * s) >>> 16);
         end
         MODE_NEG: begin
            for (int i = 0; i < 3; i++) rv[i] = clamp_q(-a[i]);
         end
         MODE_CROSS: begin
            for (int i = 0; i < 3; i++) begin
               acc = a[(i+1)%3] * b[(i+2)%3] - a[(i+2)%3] * b[(i+1)%3];
               rv[i] = clamp_q(acc >>> 16);
            end
         end
         MODE_DOT: begin
            acc = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
            r.scalar_out = clamp_q(acc >>> 16);
         end
         MODE_MAG, MODE_UNIT: begin
            sumsq = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
            mag = floor_root(sumsq);
            if (w.mode == MODE_MAG) begin
               r.scalar_out = clamp_q($signed({64'd0, mag}));
            end else if (mag == 0) begin
               r.zero_vector = 1'b1;
            end else begin
               // The quotient is formed on the magnitude of each component,
               // so it truncates toward zero before the sign goes back on.
               for (int i = 0; i < 3; i++) begin
                  q = ((a[i] < 0 ? -a[i] : a[i]) << 16) / {64'd0, mag};
                  rv[i] = clamp_q(a[i] < 0 ? -$signed(q) : $signed(q));
               end
            end
         end
         MODE_EQUALS: begin
            r.is_equal = (a[0] == b[0] && a[1] == b[1] && a[2] == b[2]);
         end
         default: ;
      endcase
      r.r_x = rv[0];
      r.r_y = rv[1];
      r.r_z = rv[2];
      return r;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
         failures++;
      end
   endtask

   initial begin
      failures = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset) begin
         if (start && !busy) begin
            vector_results.push_back(vector_result(req_word));
         end
         if (rsp_valid) begin
            if (vector_results.size() == 0) begin
               $error("response word with none expected");
               failures++;
            end else begin
               want = vector_results.pop_front();
               check_field("r_x", want.r_x, rsp_word.r_x);
               check_field("r_y", want.r_y, rsp_word.r_y);
               check_field("r_z", want.r_z, rsp_word.r_z);
               check_field("scalar_out", want.scalar_out, rsp_word.scalar_out);
               check_field("is_equal", want.is_equal, rsp_word.is_equal);
               check_field("zero_vector", want.zero_vector, rsp_word.zero_vector);
            end
         end
         pending = vector_results.size();
      end
   end

endmodule

// ===== bench/vector3_arithmetic_unit_test.sv =====
// Top of the vector unit testbench: clock, reset, directed and random request
// words with sender gaps, and the verdict. Depends on v3au_pkg, the unit and
// vector3_arithmetic_unit_checker.
module vector3_arithmetic_unit_test import v3au_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   req_word_type req_word = '0;
   logic         rsp_valid;
   rsp_word_type rsp_word;
   int           failures;
   int           pending;
   int           words_sent = 0;
   int           mode_hits [16];

   always #5 clock = ~clock;

   vector3_arithmetic_unit dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_word(req_word), .rsp_valid(rsp_valid), .rsp_word(rsp_word)
   );

   vector3_arithmetic_unit_checker checker_i (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_word(req_word), .rsp_valid(rsp_valid), .rsp_word(rsp_word),
      .failures(failures), .pending(pending)
   );

   // Extremes and small values are favored so saturation is reached often.
   function automatic logic [31:0] pick_q();
      case ($urandom_range(0, 9))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return 32'h0;
         3: return $urandom_range(0, 1) ? 32'h00010000 : 32'hffff0000;
         4, 5: return $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
         default: return $urandom();
      endcase
   endfunction

   task automatic send_word(input req_word_type w, input int idle_pct);
      logic was_busy;
      while ($urandom_range(1, 100) <= idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_word <= w;
      mode_hits[w.mode]++;
      do begin
         @(negedge clock);
         was_busy = busy;
         @(posedge clock);
      end while (was_busy);
      words_sent++;
   endtask

   task automatic send_vectors(input logic [3:0] mode, input logic [31:0] ax,
                               input logic [31:0] ay, input logic [31:0] az,
                               input logic [31:0] bx, input logic [31:0] by,
                               input logic [31:0] bz, input logic [31:0] s);
      req_word_type w;
      w.mode = mode;
      w.a_x = ax;
      w.a_y = ay;
      w.a_z = az;
      w.b_x = bx;
      w.b_y = by;
      w.b_z = bz;
      w.scalar_in = s;
      send_word(w, 0);
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
   endtask

   initial begin
      req_word_type w;
      int idle_pct;
      int covered;
      foreach (mode_hits[i]) mode_hits[i] = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words: each mode, saturation corners, zero vector, bad modes.
      send_vectors(MODE_ADD, 32'h7fffffff, 32'h80000000, 32'h1, 32'h1, 32'hffffffff,
                   32'h2, 32'h0);
      send_vectors(MODE_SUB, 32'h80000000, 32'h7fffffff, 32'h5, 32'h1, 32'hffffffff,
                   32'h5, 32'h0);
      send_vectors(MODE_ADDS, 32'h7fffffff, 32'h80000000, 32'h0, 32'h0, 32'h0, 32'h0,
                   32'h7fffffff);
      send_vectors(MODE_SUBS, 32'h80000000, 32'h7fffffff, 32'h0, 32'h0, 32'h0, 32'h0,
                   32'h80000000);
      send_vectors(MODE_SCALE, 32'h7fffffff, 32'h80000000, 32'hffffffff, 32'h0, 32'h0,
                   32'h0, 32'h80000000);
      send_vectors(MODE_SCALE, 32'h00018000, 32'hfffe8000, 32'h1, 32'h0, 32'h0, 32'h0,
                   32'h00008000);
      send_vectors(MODE_NEG, 32'h80000000, 32'h7fffffff, 32'h0, 32'h0, 32'h0, 32'h0,
                   32'h0);
      send_vectors(MODE_CROSS, 32'h00010000, 32'h0, 32'h0, 32'h0, 32'h00010000, 32'h0,
                   32'h0);
      send_vectors(MODE_CROSS, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                   32'h80000000, 32'h7fffffff, 32'h0);
      send_vectors(MODE_DOT, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                   32'h80000000, 32'h80000000, 32'h0);
      send_vectors(MODE_DOT, 32'h00020000, 32'hffff0000, 32'h1, 32'h00030000, 32'h2,
                   32'hffffffff, 32'h0);
      send_vectors(MODE_MAG, 32'h80000000, 32'h80000000, 32'h80000000, 32'h0, 32'h0,
                   32'h0, 32'h0);
      send_vectors(MODE_MAG, 32'h00030000, 32'h00040000, 32'h0, 32'h0, 32'h0, 32'h0,
                   32'h0);
      send_vectors(MODE_UNIT, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
      send_vectors(MODE_UNIT, 32'h80000000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
      send_vectors(MODE_UNIT, 32'h1, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
      send_vectors(MODE_UNIT, 32'hfffd0000, 32'h00040000, 32'h7fffffff, 32'h0, 32'h0,
                   32'h0, 32'h0);
      send_vectors(MODE_EQUALS, 32'h80000000, 32'h7fffffff, 32'h1, 32'h80000000,
                   32'h7fffffff, 32'h1, 32'h0);
      send_vectors(MODE_EQUALS, 32'h80000000, 32'h7fffffff, 32'h1, 32'h80000000,
                   32'h7fffffff, 32'h0, 32'h0);
      send_vectors(4'd11, 32'h1, 32'h1, 32'h1, 32'h1, 32'h1, 32'h1, 32'h1);
      send_vectors(4'd15, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                   32'hffffffff, 32'hffffffff, 32'hffffffff);
      drain();

      for (int n = 0; n < 500; n++) begin
         idle_pct = (n < 170) ? 18 : (n < 340) ? 79 : 0;
         if (n == 170 || n == 340) drain();
         w.mode = ($urandom_range(0, 19) != 0) ? 4'($urandom_range(0, 10))
                                                : 4'($urandom_range(11, 15));
         w.a_x = pick_q();
         w.a_y = pick_q();
         w.a_z = pick_q();
         w.b_x = pick_q();
         w.b_y = pick_q();
         w.b_z = pick_q();
         w.scalar_in = pick_q();
         if (w.mode == MODE_EQUALS && $urandom_range(0, 1)) begin
            w.b_x = w.a_x;
            w.b_y = w.a_y;
            w.b_z = $urandom_range(0, 2) ? w.a_z : w.a_z ^ (32'd1 << $urandom_range(0, 31));
         end
         if (w.mode == MODE_UNIT && $urandom_range(0, 5) == 0) begin
            w.a_x = '0;
            w.a_y = '0;
            w.a_z = '0;
         end
         send_word(w, idle_pct);
      end
      drain();
      repeat (PIPE_DEPTH + 10) @(posedge clock);

      covered = 0;
      foreach (mode_hits[i]) if (mode_hits[i] != 0) covered++;
      $display("Sent %0d request words over %0d distinct mode codes, %0d of them unit asks.",
               words_sent, covered, mode_hits[MODE_UNIT]);
      if (failures == 0) begin
         $display("vector3_arithmetic_unit_test: PASS");
      end else begin
         $display("vector3_arithmetic_unit_test: FAIL");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("vector3_arithmetic_unit_test: FAIL");
      $finish;
   end

endmodule

// ===== vector3_arithmetic_unit.f =====
hw/rtl/v3au_pkg.sv
hw/rtl/v3au_sqrt.sv
hw/rtl/v3au_div.sv
hw/rtl/vector3_arithmetic_unit.sv
bench/vector3_arithmetic_unit_checker.sv
bench/vector3_arithmetic_unit_test.sv
